// File: src/tmh_pkg.sv
// ----------------------------------------------------------------------------
// tmh_pkg
// Shared types and constants for the timer min-heap core.
// ----------------------------------------------------------------------------
package tmh_pkg;

   // Field widths
   localparam int CMD_W  = 3;
   localparam int ID_W   = 10;
   localparam int TO_W   = 32;
   localparam int NOW_W  = 48;
   localparam int DL_W   = 49;
   localparam int KIND_W = 2;
   localparam int STS_W  = 2;
   localparam int WAIT_W = 33;
   localparam int HEAP_W = DL_W + ID_W;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RESET  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd2;

   // Status codes
   localparam logic [STS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL     = 2'd2;

   // Controller states, one-hot
   typedef enum logic [15:0] {
      ST_INIT   = 16'h0001,
      ST_IDLE   = 16'h0002,
      ST_LOOK   = 16'h0004,
      ST_RESIFT = 16'h0008,
      ST_UPCMP  = 16'h0010,
      ST_DN     = 16'h0020,
      ST_DL     = 16'h0040,
      ST_DR     = 16'h0080,
      ST_DMV    = 16'h0100,
      ST_PLACE  = 16'h0200,
      ST_GOT    = 16'h0400,
      ST_TRD    = 16'h0800,
      ST_TCHK   = 16'h1000,
      ST_CLR    = 16'h2000,
      ST_CLRW   = 16'h4000,
      ST_RESP   = 16'h8000
   } state_type;

endpackage

// File: src/tmh_ram.sv
// ----------------------------------------------------------------------------
// tmh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/timer_min_heap_with_id_map_core.sv
// ----------------------------------------------------------------------------
// timer_min_heap_with_id_map_core
// Binary min-heap timer queue with an id-to-slot map, both in RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | command, timer_id, timeout_ms, now_ms
//  rsp     | out       | rsp_valid/stall   | kind, expired_id, status, wait_ms, last
//
//  One request at a time. Sifting up costs one compare-and-move per heap level;
//  sifting down reads each child and moves the smaller up (ST_DN, ST_DL, ST_DR,
//  ST_DMV), as the heap RAM has one registered read port. Tick pops each expired
//  timer in turn; clear frees the slot of each stored timer. After reset the slot
//  map is swept while req_stall is high. A stalled rsp holds the core.
// ----------------------------------------------------------------------------
module timer_min_heap_with_id_map_core #(
   parameter int CAPACITY = 32,
   parameter int ID_COUNT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tmh_pkg::CMD_W-1:0]     req_command,
   input  logic [tmh_pkg::ID_W-1:0]      req_timer_id,
   input  logic [tmh_pkg::TO_W-1:0]      req_timeout_ms,
   input  logic [tmh_pkg::NOW_W-1:0]     req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tmh_pkg::KIND_W-1:0]    rsp_kind,
   output logic [tmh_pkg::ID_W-1:0]      rsp_expired_id,
   output logic [tmh_pkg::STS_W-1:0]     rsp_status,
   output logic signed [tmh_pkg::WAIT_W-1:0] rsp_wait_ms,
   output logic                          rsp_last
);
   import tmh_pkg::*;

   localparam int IW = $clog2(CAPACITY);       // heap index
   localparam int CW = $clog2(CAPACITY + 1);   // timer count
   localparam int AW = $clog2(ID_COUNT);       // slot map address
   localparam int SW = IW + 1;                 // slot entry: valid + index

   state_type state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [DL_W-1:0]   dl_ff, dl_in;
   logic [NOW_W-1:0]  now_ff, now_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     hole_ff, hole_in;
   logic [DL_W-1:0]   item_dl_ff, item_dl_in;
   logic [ID_W-1:0]   item_id_ff, item_id_in;
   logic              best_sel_ff, best_sel_in;
   logic [DL_W-1:0]   best_dl_ff, best_dl_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [STS_W-1:0]  status_ff, status_in;
   logic [AW-1:0]     clr_ff, clr_in;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [ID_W-1:0]   rsp_expired_id_ff;
   logic [STS_W-1:0]  rsp_status_ff;
   logic [WAIT_W-1:0] rsp_wait_ms_ff;
   logic              rsp_last_ff;

   // memory ports
   logic              heap_we;
   logic [IW-1:0]     heap_waddr, heap_raddr;
   logic [HEAP_W-1:0] heap_wdata, heap_rdata;
   logic              slot_we;
   logic [AW-1:0]     slot_waddr, slot_raddr;
   logic [SW-1:0]     slot_wdata, slot_rdata;

   // result staging
   logic              put_en;
   logic [KIND_W-1:0] put_kind;
   logic [ID_W-1:0]   put_id;
   logic [STS_W-1:0]  put_status;
   logic [WAIT_W-1:0] put_wait;
   logic              put_last;

   logic              req_acc, can_put, in_range, present;
   logic [DL_W-1:0]   hrd_dl;
   logic [ID_W-1:0]   hrd_id;
   logic [IW-1:0]     parent_idx, grand_idx;
   logic [IW+1:0]     left_idx, right_idx;
   logic [DL_W-1:0]   wait_diff;
   logic [31:0]       wait_cap;

   tmh_ram #(.WIDTH(HEAP_W), .DEPTH(CAPACITY)) u_heap (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata)
   );

   tmh_ram #(.WIDTH(SW), .DEPTH(ID_COUNT)) u_slot (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   // decode helpers
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign can_put   = ~rsp_valid_ff | ~rsp_stall;
   assign in_range  = (32'(req_timer_id) < ID_COUNT);
   assign hrd_dl    = heap_rdata[HEAP_W-1:ID_W];
   assign hrd_id    = heap_rdata[ID_W-1:0];
   assign present   = slot_rdata[IW] & (32'(slot_rdata[IW-1:0]) < 32'(count_ff));
   assign parent_idx = IW'((hole_ff - 1'b1) >> 1);
   assign grand_idx  = IW'((parent_idx - 1'b1) >> 1);
   assign left_idx   = {1'b0, hole_ff, 1'b1};
   assign right_idx  = left_idx + 1'b1;

   // time to next deadline, floored at zero and capped at 32 bits
   assign wait_diff = hrd_dl - {1'b0, now_ff};
   assign wait_cap  = (wait_diff[DL_W-1:32] != '0) ? 32'hFFFF_FFFF : wait_diff[31:0];

   // controller
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      id_in       = id_ff;
      dl_in       = dl_ff;
      now_in      = now_ff;
      count_in    = count_ff;
      hole_in     = hole_ff;
      item_dl_in  = item_dl_ff;
      item_id_in  = item_id_ff;
      best_sel_in = best_sel_ff;
      best_dl_in  = best_dl_ff;
      best_id_in  = best_id_ff;
      best_idx_in = best_idx_ff;
      status_in   = status_ff;
      clr_in      = clr_ff;
      heap_we     = 1'b0;
      heap_waddr  = hole_ff;
      heap_wdata  = {item_dl_ff, item_id_ff};
      heap_raddr  = '0;
      slot_we     = 1'b0;
      slot_waddr  = AW'(item_id_ff);
      slot_wdata  = {1'b1, hole_ff};
      slot_raddr  = AW'(req_timer_id);
      put_en      = 1'b0;
      put_kind    = KIND_STATUS;
      put_id      = '0;
      put_status  = '0;
      put_wait    = '0;
      put_last    = 1'b1;

      case (state_ff)
         // sweep the slot map after reset
         ST_INIT: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == AW'(ID_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // take a request; slot and root reads go out in the same cycle
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in    = req_command;
               id_in     = req_timer_id;
               dl_in     = DL_W'(req_now_ms) + DL_W'(req_timeout_ms);
               now_in    = req_now_ms;
               status_in = STS_OK;
               case (req_command)
                  CMD_ADD, CMD_RESET, CMD_REMOVE: begin
                     if (in_range) begin
                        state_in = ST_LOOK;
                     end else begin
                        status_in = STS_NOTFOUND;
                        state_in  = ST_RESP;
                     end
                  end
                  CMD_TICK:  state_in = ST_TCHK;
                  CMD_CLEAR: state_in = ST_CLR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         // slot map answer is here
         ST_LOOK: begin
            item_dl_in = dl_ff;
            item_id_in = id_ff;
            case (cmd_ff)
               CMD_ADD: begin
                  if (present) begin
                     hole_in  = slot_rdata[IW-1:0];
                     state_in = ST_RESIFT;
                  end else if (32'(count_ff) >= CAPACITY) begin
                     status_in = STS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     hole_in  = IW'(count_ff);
                     count_in = count_ff + 1'b1;
                     state_in = ST_RESIFT;
                  end
               end
               CMD_RESET: begin
                  if (present) begin
                     hole_in  = slot_rdata[IW-1:0];
                     state_in = ST_RESIFT;
                  end else begin
                     status_in = STS_NOTFOUND;
                     state_in  = ST_RESP;
                  end
               end
               default: begin
                  // remove: drop the id, refill the slot from the tail
                  if (present) begin
                     slot_we    = 1'b1;
                     slot_waddr = AW'(id_ff);
                     slot_wdata = '0;
                     count_in   = count_ff - 1'b1;
                     if (32'(slot_rdata[IW-1:0]) == 32'(count_ff) - 1) begin
                        state_in = ST_RESP;
                     end else begin
                        hole_in    = slot_rdata[IW-1:0];
                        heap_raddr = IW'(count_ff - 1'b1);
                        state_in   = ST_GOT;
                     end
                  end else begin
                     status_in = STS_NOTFOUND;
                     state_in  = ST_RESP;
                  end
               end
            endcase
         end
         // moving entry read from the tail
         ST_GOT: begin
            item_dl_in = hrd_dl;
            item_id_in = hrd_id;
            state_in   = ST_RESIFT;
         end
         ST_RESIFT: begin
            if (hole_ff != '0) begin
               heap_raddr = parent_idx;
               state_in   = ST_UPCMP;
            end else begin
               state_in = ST_DN;
            end
         end
         // sift up: parent moves down into the hole
         ST_UPCMP: begin
            if (item_dl_ff < hrd_dl) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rdata;
               slot_we    = 1'b1;
               slot_waddr = AW'(hrd_id);
               hole_in    = parent_idx;
               if (parent_idx != '0) begin
                  heap_raddr = grand_idx;
               end else begin
                  state_in = ST_DN;
               end
            end else begin
               state_in = ST_DN;
            end
         end
         // sift down: fetch left child
         ST_DN: begin
            if (32'(left_idx) < 32'(count_ff)) begin
               heap_raddr = IW'(left_idx);
               state_in   = ST_DL;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_DL: begin
            if (hrd_dl < item_dl_ff) begin
               best_sel_in = 1'b1;
               best_dl_in  = hrd_dl;
               best_id_in  = hrd_id;
               best_idx_in = IW'(left_idx);
            end else begin
               best_sel_in = 1'b0;
               best_dl_in  = item_dl_ff;
            end
            if (32'(right_idx) < 32'(count_ff)) begin
               heap_raddr = IW'(right_idx);
               state_in   = ST_DR;
            end else begin
               state_in = ST_DMV;
            end
         end
         ST_DR: begin
            if (hrd_dl < best_dl_ff) begin
               best_sel_in = 1'b1;
               best_dl_in  = hrd_dl;
               best_id_in  = hrd_id;
               best_idx_in = IW'(right_idx);
            end
            state_in = ST_DMV;
         end
         // smaller child moves up into the hole
         ST_DMV: begin
            if (best_sel_ff) begin
               heap_we    = 1'b1;
               heap_wdata = {best_dl_ff, best_id_ff};
               slot_we    = 1'b1;
               slot_waddr = AW'(best_id_ff);
               hole_in    = best_idx_ff;
               state_in   = ST_DN;
            end else begin
               state_in = ST_PLACE;
            end
         end
         // drop the moving entry into its final slot
         ST_PLACE: begin
            heap_we = 1'b1;
            slot_we = 1'b1;
            state_in = (cmd_ff == CMD_TICK) ? ST_TRD : ST_RESP;
         end
         ST_TRD: begin
            state_in = ST_TCHK;
         end
         // root is here: pop it or report the wait
         ST_TCHK: begin
            if (can_put) begin
               put_en = 1'b1;
               if (count_ff != '0 && hrd_dl <= {1'b0, now_ff}) begin
                  put_kind   = KIND_EXPIRED;
                  put_id     = hrd_id;
                  put_last   = 1'b0;
                  slot_we    = 1'b1;
                  slot_waddr = AW'(hrd_id);
                  slot_wdata = '0;
                  count_in   = count_ff - 1'b1;
                  hole_in    = '0;
                  if (count_ff == CW'(1)) begin
                     state_in = ST_TRD;
                  end else begin
                     heap_raddr = IW'(count_ff - 1'b1);
                     state_in   = ST_GOT;
                  end
               end else begin
                  put_kind = KIND_WAIT;
                  if (count_ff == '0) begin
                     put_wait = '1;
                  end else if (hrd_dl > {1'b0, now_ff}) begin
                     put_wait = {1'b0, wait_cap};
                  end else begin
                     put_wait = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         // clear: walk the heap from the tail, invalidating ids
         ST_CLR: begin
            if (count_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               heap_raddr = IW'(count_ff - 1'b1);
               state_in   = ST_CLRW;
            end
         end
         ST_CLRW: begin
            slot_we    = 1'b1;
            slot_waddr = AW'(hrd_id);
            slot_wdata = '0;
            count_in   = count_ff - 1'b1;
            state_in   = ST_CLR;
         end
         ST_RESP: begin
            if (can_put) begin
               put_en     = 1'b1;
               put_status = status_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      dl_ff       <= dl_in;
      now_ff      <= now_in;
      hole_ff     <= hole_in;
      item_dl_ff  <= item_dl_in;
      item_id_ff  <= item_id_in;
      best_sel_ff <= best_sel_in;
      best_dl_ff  <= best_dl_in;
      best_id_ff  <= best_id_in;
      best_idx_ff <= best_idx_in;
      status_ff   <= status_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (put_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (put_en) begin
         rsp_kind_ff       <= put_kind;
         rsp_expired_id_ff <= put_id;
         rsp_status_ff     <= put_status;
         rsp_wait_ms_ff    <= put_wait;
         rsp_last_ff       <= put_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_expired_id = rsp_expired_id_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_wait_ms    = rsp_wait_ms_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
